// ===== rtl/hrrn_pkg.sv =====
// Package for the HRRN ready queue: state machine type, status codes, input kinds and the alpha scale.
// No dependencies.
package hrrn_pkg;

  // Result status codes.
  localparam logic [1:0] STAT_ADDED      = 2'd0;
  localparam logic [1:0] STAT_DISPATCHED = 2'd1;
  localparam logic [1:0] STAT_EMPTY      = 2'd2;
  localparam logic [1:0] STAT_FULL       = 2'd3;

  // Input item kinds.
  localparam logic KIND_ADD      = 1'b0;
  localparam logic KIND_DISPATCH = 1'b1;

  // Alpha is a fraction over this value.
  localparam int unsigned ALPHA_ONE = 256;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_EST,
    ST_SCAN_MUL,
    ST_SCAN_CMP,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/hrrn_if.sv =====
// Valid/ready channel interfaces for the HRRN ready queue.
// No dependencies.
interface hrrn_in_if #(parameter int TIME_BITS = 32);
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [15:0]          proc_id;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] est_burst;
  logic [TIME_BITS-1:0] prev_burst;
  modport source(output valid, kind, proc_id, now, est_burst, prev_burst, input ready);
  modport sink(input valid, kind, proc_id, now, est_burst, prev_burst, output ready);
endinterface

interface hrrn_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] chosen_id;
  modport source(output valid, status, chosen_id, input ready);
  modport sink(input valid, status, chosen_id, output ready);
endinterface

interface hrrn_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ===== rtl/hrrn_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module hrrn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== rtl/hrrn_ready_queue_select.sv =====
// Top level of the HRRN ready queue.
// Depends on hrrn_pkg, hrrn_if and hrrn_ram.
//
// Ready table for a highest-response-ratio-next scheduler. The table lives in
// one RAM row per entry (id, ready time, estimate, last burst). An add item,
// or a dispatch on an empty table, is answered straight from the idle state.
// A dispatch item reads every valid entry once through the RAM read port in
// four steps per entry (read, estimate multiply, cross multiply, compare),
// then closes the gap behind the winner with a read and a write per moved
// entry. One item is in work at a time; the result register frees the input
// side as soon as the result is taken. No clearing pass is needed after
// reset.
module hrrn_ready_queue_select
  import hrrn_pkg::*;
#(
  parameter int ENTRIES   = 16,
  parameter int TIME_BITS = 32
) (
  input logic        clk,
  input logic        rst,
  hrrn_in_if.sink    in_ch,
  hrrn_out_if.source out_ch,
  hrrn_cfg_if.sink   cfg
);
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int RW = 16 + 3 * TIME_BITS;
  localparam int EW = TIME_BITS + 1;
  localparam int PW = TIME_BITS + EW;

  state_t state, state_next;

  logic [8:0]           alpha;
  logic [CW-1:0]        count;
  logic [CW-1:0]        idx;
  logic [AW-1:0]        best;
  logic                 is_first;
  logic [TIME_BITS-1:0] now_q;
  logic [TIME_BITS-1:0] wait_q, bw;
  logic [EW-1:0]        e_q, be;
  logic [PW-1:0]        lhs, rhs;
  logic [15:0]          best_id;
  logic [1:0]           res_status;
  logic [15:0]          res_id;
  logic                 res_valid;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr, rd_addr;
  logic [RW-1:0]        wr_data, rd_data;

  logic [15:0]          r_id;
  logic [TIME_BITS-1:0] r_ready, r_est, r_last;
  logic [8:0]           a_sat;
  logic [TIME_BITS+8:0] esum;
  logic [EW-1:0]        e_raw;

  hrrn_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  assign {r_id, r_ready, r_est, r_last} = rd_data;
  assign a_sat = (alpha > 9'(ALPHA_ONE)) ? 9'(ALPHA_ONE) : alpha;
  assign esum  = (TIME_BITS+9)'(a_sat) * (TIME_BITS+9)'(r_last)
               + (TIME_BITS+9)'(9'(ALPHA_ONE) - a_sat) * (TIME_BITS+9)'(r_est);
  assign e_raw = esum[TIME_BITS+8:8];

  assign in_ch.ready      = (state == ST_IDLE) && !res_valid;
  assign cfg.ready        = 1'b1;
  assign out_ch.valid     = res_valid;
  assign out_ch.status    = res_status;
  assign out_ch.chosen_id = res_id;

  // RAM addressing and write data.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[AW-1:0];
    wr_data = {in_ch.proc_id, in_ch.now, in_ch.est_burst, in_ch.prev_burst};
    rd_addr = idx[AW-1:0];
    if (state == ST_IDLE) begin
      wr_en = in_ch.valid && in_ch.ready && in_ch.kind == KIND_ADD
              && count < CW'(ENTRIES);
    end else if (state == ST_MOVE_WR) begin
      wr_en   = 1'b1;
      wr_addr = AW'(idx - 1'b1);
      wr_data = rd_data;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_ch.valid && in_ch.ready && in_ch.kind == KIND_DISPATCH
            && count != '0) begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD:  state_next = ST_SCAN_EST;
      ST_SCAN_EST: state_next = ST_SCAN_MUL;
      ST_SCAN_MUL: state_next = ST_SCAN_CMP;
      ST_SCAN_CMP: state_next = (idx + 1'b1 < count) ? ST_SCAN_RD : ST_MOVE_RD;
      ST_MOVE_RD:  state_next = (idx < count) ? ST_MOVE_WR : ST_OUT;
      ST_MOVE_WR:  state_next = ST_MOVE_RD;
      ST_OUT:      state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Control registers and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha     <= 9'(ALPHA_ONE / 2);
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) alpha <= cfg.data;
      if (out_ch.valid && out_ch.ready) res_valid <= 1'b0;
      if (state == ST_IDLE && in_ch.valid && in_ch.ready) begin
        if (in_ch.kind == KIND_ADD) begin
          res_valid  <= 1'b1;
          res_id     <= '0;
          if (count < CW'(ENTRIES)) begin
            count      <= count + 1'b1;
            res_status <= STAT_ADDED;
          end else begin
            res_status <= STAT_FULL;
          end
        end else if (count == '0) begin
          res_valid  <= 1'b1;
          res_status <= STAT_EMPTY;
          res_id     <= '0;
        end
      end
      if (state == ST_OUT) begin
        res_valid  <= 1'b1;
        res_status <= STAT_DISPATCHED;
        res_id     <= best_id;
        count      <= count - 1'b1;
      end
    end
  end

  // Scan datapath: estimate, wait, cross products, running best, move index.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        idx      <= '0;
        is_first <= 1'b1;
        now_q    <= in_ch.now;
      end
      ST_SCAN_EST: begin
        e_q    <= (e_raw == '0) ? EW'(1) : e_raw;
        wait_q <= (now_q >= r_ready) ? now_q - r_ready : '0;
      end
      ST_SCAN_MUL: begin
        lhs <= PW'(wait_q) * PW'(be);
        rhs <= PW'(bw) * PW'(e_q);
      end
      ST_SCAN_CMP: begin
        // The read address has not moved, so the RAM still shows this row.
        if (is_first || lhs > rhs) begin
          best    <= idx[AW-1:0];
          best_id <= r_id;
          bw      <= wait_q;
          be      <= e_q;
        end
        is_first <= 1'b0;
        if (idx + 1'b1 < count) idx <= idx + 1'b1;
        else idx <= CW'(is_first || lhs > rhs ? idx : CW'(best)) + 1'b1;
      end
      ST_MOVE_WR: idx <= idx + 1'b1;
      default: ;
    endcase
  end

`ifndef SYNTH
  // A result is never pending in the scan read state.
  a_no_res_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN_RD) |-> !res_valid) else $error("result during scan");
  // Count never exceeds the table depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ENTRIES)) else $error("count overflow");
  // A dispatch completion always decrements a non-zero count.
  a_out_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |-> count != '0) else $error("dispatch on empty");
`endif
endmodule
